FILE: rtl/cfr_pkg.sv
// cfr_pkg: shared types and constants for the command frame receiver.
// No dependencies; used by cfr_parser and command_frame_receiver.

package cfr_pkg;

    // Longest accepted write block, and the command type that carries data
    localparam int unsigned MAX_DATA   = 512;
    localparam logic [7:0]  WRITE_TYPE = 8'd2;

    // Data byte counter must hold MAX_DATA itself
    localparam int unsigned DCNT_W = $clog2(MAX_DATA + 1);

    // Header bytes
    localparam logic [7:0] HDR_C    = 8'h43;
    localparam logic [7:0] HDR_M    = 8'h4D;
    localparam logic [7:0] HDR_D    = 8'h44;

    // Header positions
    localparam logic [3:0] POS_C    = 4'd0;
    localparam logic [3:0] POS_M    = 4'd1;
    localparam logic [3:0] POS_D    = 4'd2;
    localparam logic [3:0] POS_TYPE = 4'd3;
    localparam logic [3:0] POS_ADR0 = 4'd4;
    localparam logic [3:0] POS_ADR3 = 4'd7;
    localparam logic [3:0] POS_LEN0 = 4'd8;
    localparam logic [3:0] POS_LEN1 = 4'd9;
    localparam logic [3:0] POS_CHK  = 4'd10;

    // Result kinds
    localparam logic [2:0] KIND_HDR_BYTE = 3'd0;
    localparam logic [2:0] KIND_HDR_REJ  = 3'd1;
    localparam logic [2:0] KIND_CMD_OK   = 3'd2;
    localparam logic [2:0] KIND_DATA     = 3'd3;
    localparam logic [2:0] KIND_LAST     = 3'd4;
    localparam logic [2:0] KIND_BAD_LEN  = 3'd5;

    // One result transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  cmd_code;
        logic [31:0] address;
        logic [15:0] data_length;
        logic [7:0]  header_checksum;
        logic [8:0]  data_index;
        logic [7:0]  data_value;
        logic [7:0]  data_checksum;
    } t_result;

endpackage

FILE: rtl/cfr_parser.sv
// cfr_parser: frame state registers and the combinational byte parser.
// Depends on cfr_pkg; instantiated by command_frame_receiver.

module cfr_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_rx_byte,
    output cfr_pkg::t_result  o_result
);

    logic                       r_data_mode, n_data_mode;
    logic [3:0]                 r_hdr_pos, n_hdr_pos;
    logic [7:0]                 r_hdr_xor, n_hdr_xor;
    logic [7:0]                 r_type, n_type;
    logic [31:0]                r_addr, n_addr;
    logic [15:0]                r_len, n_len;
    logic [cfr_pkg::DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [7:0]                 r_dxor, n_dxor;
    logic [7:0]                 r_saved_xor, n_saved_xor;

    logic [7:0]                 hx;
    logic [7:0]                 dx;
    logic [cfr_pkg::DCNT_W-1:0] dcnt_inc;
    logic                       reject;
    logic                       bad_len;
    logic                       last_byte;
    cfr_pkg::t_result           res;

    assign hx       = (r_hdr_pos == cfr_pkg::POS_C) ? 8'h00 : r_hdr_xor;
    assign dx       = r_dxor ^ i_rx_byte;
    assign dcnt_inc = r_dcnt + 1'b1;
    assign last_byte = {1'b0, 16'(dcnt_inc)} >= {1'b0, r_len};
    assign bad_len  = (r_len == 16'd0) ||
                      ({1'b0, r_len} > 17'(cfr_pkg::MAX_DATA));

    // Next state and result for the current byte
    always_comb begin
        n_data_mode = r_data_mode;
        n_hdr_pos   = r_hdr_pos;
        n_hdr_xor   = r_hdr_xor;
        n_type      = r_type;
        n_addr      = r_addr;
        n_len       = r_len;
        n_dcnt      = r_dcnt;
        n_dxor      = r_dxor;
        n_saved_xor = r_saved_xor;
        reject      = 1'b0;
        res         = '0;

        if (r_data_mode) begin
            res.cmd_code        = r_type;
            res.address         = r_addr;
            res.data_length     = r_len;
            res.header_checksum = r_saved_xor;
            res.data_index      = 9'(r_dcnt);
            res.data_value      = i_rx_byte;
            if (last_byte) begin
                res.kind          = cfr_pkg::KIND_LAST;
                res.data_checksum = dx;
                n_data_mode       = 1'b0;
                n_hdr_pos         = cfr_pkg::POS_C;
                n_dcnt            = '0;
                n_dxor            = 8'h00;
            end else begin
                res.kind = cfr_pkg::KIND_DATA;
                n_dcnt   = dcnt_inc;
                n_dxor   = dx;
            end
        end else begin
            // Field capture and fixed-byte checks
            if (r_hdr_pos == cfr_pkg::POS_C) begin
                reject = (i_rx_byte != cfr_pkg::HDR_C);
            end else if (r_hdr_pos == cfr_pkg::POS_M) begin
                reject = (i_rx_byte != cfr_pkg::HDR_M);
            end else if (r_hdr_pos == cfr_pkg::POS_D) begin
                reject = (i_rx_byte != cfr_pkg::HDR_D);
            end else if (r_hdr_pos == cfr_pkg::POS_TYPE) begin
                n_type = i_rx_byte;
            end else if (r_hdr_pos >= cfr_pkg::POS_ADR0 &&
                         r_hdr_pos <= cfr_pkg::POS_ADR3) begin
                n_addr = {r_addr[23:0], i_rx_byte};
            end else if (r_hdr_pos == cfr_pkg::POS_LEN0 ||
                         r_hdr_pos == cfr_pkg::POS_LEN1) begin
                n_len = {r_len[7:0], i_rx_byte};
            end

            if (r_hdr_pos >= cfr_pkg::POS_CHK && i_rx_byte == hx) begin
                // Checksum good: frame complete
                res.cmd_code        = r_type;
                res.address         = r_addr;
                res.data_length     = r_len;
                res.header_checksum = hx;
                n_saved_xor = hx;
                n_hdr_pos   = cfr_pkg::POS_C;
                n_hdr_xor   = 8'h00;
                n_dcnt      = '0;
                n_dxor      = 8'h00;
                if (r_type == cfr_pkg::WRITE_TYPE && bad_len) begin
                    res.kind = cfr_pkg::KIND_BAD_LEN;
                end else begin
                    res.kind    = cfr_pkg::KIND_CMD_OK;
                    n_data_mode = (r_type == cfr_pkg::WRITE_TYPE);
                end
            end else if (reject || r_hdr_pos >= cfr_pkg::POS_CHK) begin
                // Bad header byte or checksum: restart, byte dropped
                res.kind  = cfr_pkg::KIND_HDR_REJ;
                n_hdr_pos = cfr_pkg::POS_C;
                n_hdr_xor = 8'h00;
            end else begin
                res.kind  = cfr_pkg::KIND_HDR_BYTE;
                n_hdr_xor = hx ^ i_rx_byte;
                n_hdr_pos = r_hdr_pos + 4'd1;
            end
        end
    end

    assign o_result = res;

    // State registers, advanced once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_mode <= 1'b0;
            r_hdr_pos   <= cfr_pkg::POS_C;
            r_hdr_xor   <= 8'h00;
            r_type      <= 8'h00;
            r_addr      <= 32'h0;
            r_len       <= 16'h0;
            r_dcnt      <= '0;
            r_dxor      <= 8'h00;
            r_saved_xor <= 8'h00;
        end else if (i_take) begin
            r_data_mode <= n_data_mode;
            r_hdr_pos   <= n_hdr_pos;
            r_hdr_xor   <= n_hdr_xor;
            r_type      <= n_type;
            r_addr      <= n_addr;
            r_len       <= n_len;
            r_dcnt      <= n_dcnt;
            r_dxor      <= n_dxor;
            r_saved_xor <= n_saved_xor;
        end
    end

endmodule

FILE: rtl/command_frame_receiver.sv
// command_frame_receiver: top level, byte parser plus two-entry result buffer.
// Depends on cfr_pkg and cfr_parser.
//
//  channel  direction  handshake                  payload
//  in       into block i_in_valid / o_in_stall    i_rx_byte
//  out      from block o_out_valid / i_out_stall  o_kind .. o_data_checksum
//
// One byte per cycle while o_in_stall is low; each byte gives exactly one
// result, registered in the output register or the skid entry. A skid entry
// behind the output register lets a byte be taken while a result waits, so
// o_in_stall rises only when both entries hold results. Synchronous active-low
// reset empties the buffer and returns the parser to header mode.

module command_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_cmd_code,
    output logic [31:0] o_address,
    output logic [15:0] o_data_length,
    output logic [7:0]  o_header_checksum,
    output logic [8:0]  o_data_index,
    output logic [7:0]  o_data_value,
    output logic [7:0]  o_data_checksum
);

    logic             r_out_valid;
    logic             r_skid_valid;
    cfr_pkg::t_result r_out;
    cfr_pkg::t_result r_skid;
    cfr_pkg::t_result new_res;
    logic             in_acc;
    logic             out_acc;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_acc    = r_out_valid && !i_out_stall;

    cfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (in_acc),
        .i_rx_byte (i_rx_byte),
        .o_result  (new_res)
    );

    // Output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_acc || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc;
                    if (in_acc) begin
                        r_out <= new_res;
                    end
                end
            end else if (in_acc) begin
                r_skid       <= new_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_out.kind;
    assign o_cmd_code        = r_out.cmd_code;
    assign o_address         = r_out.address;
    assign o_data_length     = r_out.data_length;
    assign o_header_checksum = r_out.header_checksum;
    assign o_data_index      = r_out.data_index;
    assign o_data_value      = r_out.data_value;
    assign o_data_checksum   = r_out.data_checksum;

    // Skid entry is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // A transaction taken while the output is held must land in the skid entry
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("accepted byte lost while output stalled");

    // Only defined result kinds leave the block
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind <= cfr_pkg::KIND_BAD_LEN))
        else $error("undefined result kind");

endmodule
